// ----- rtl/gbhs_pkg.sv -----
package gbhs_pkg;

  localparam int OUT_CAP = 8;
  localparam int CNT_W   = $clog2(OUT_CAP + 1);

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [2:0] STS_OK            = 3'd0;
  localparam logic [2:0] STS_NOT_PERMITTED = 3'd1;
  localparam logic [2:0] STS_INVALID_ARG   = 3'd2;
  localparam logic [2:0] STS_PRECONDITION  = 3'd3;
  localparam logic [2:0] STS_UNKNOWN       = 3'd4;

  localparam logic [1:0] VERDICT_OK      = 2'd0;
  localparam logic [1:0] VERDICT_IN_USE  = 2'd1;
  localparam logic [1:0] VERDICT_BAD_ARG = 2'd2;
  localparam logic [1:0] VERDICT_OTHER   = 2'd3;

  localparam logic [1:0] PIN_STATE_INVALID = 2'd3;

  localparam logic CFG_CONTROL_ENABLED = 1'b0;
  localparam logic CFG_MAX_HOLD        = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_ms;
    logic [5:0]  pin;
    logic [1:0]  drive_state;
    logic [1:0]  end_state;
    logic [31:0] hold_ms;
    logic        force_req;
    logic [1:0]  set_verdict;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [5:0] release_pin;
    logic [1:0] release_state;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic        is_tick;
    logic        skip;
    logic        hold_nz;
    logic        pre_reject;
    logic [2:0]  pre_status;
    logic [31:0] now_ms;
    logic [5:0]  pin;
    logic [1:0]  end_state;
    logic [31:0] hold_ms;
    logic [1:0]  verdict;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  pin;
    logic [1:0]  end_state;
    logic [31:0] deadline;
  } slot_entry_t;

endpackage

// ----- rtl/gpio_bounded_hold_scheduler.sv -----
// gpio bounded hold scheduler
// input channel (in_valid / in_stall / in_item): set commands and ticks. an item
// is taken when in_valid is high and in_stall is low; a two-entry queue sits
// behind the input, so in_stall rises only when that queue is full.
// result channel (out_valid / out_stall / out_item): one status item per set
// command, and up to eight release items per tick, the final one with last set.
// a tick with nothing expired, or with control disabled, gives no item.
// config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// control enable, index 1 the longest hold in ms; cfg_ready is always high.
// a set command scans the slot table one slot per cycle through the slot memory read port,
// and its status follows the scan; a command rejected by the early checks skips the scan.
// a tick scans the slots until the last one or the eighth release; each release goes out
// when the next expired slot is found, the final one from the flush state.
// one item is handled at a time: the next queued item is taken only when the back end is idle.
// while out_stall is high the result register holds its item and the scan waits
// at the next release; the input queue keeps taking items until it is full.
// reset: all slots free, control disabled, longest hold 60000 ms, no results.
module gpio_bounded_hold_scheduler #(
  parameter int RELEASE_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbhs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gbhs_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [30:0]         cfg_data
);
  import gbhs_pkg::*;

  localparam int CMD_W = $bits(cmd_t);

  logic        ctrl_en_r, ctrl_en_nxt;
  logic [30:0] max_hold_r, max_hold_nxt;

  cmd_t             front_cmd;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [CMD_W-1:0] q_head_bits;

  assign cfg_ready = 1'b1;

  always_comb begin
    ctrl_en_nxt  = ctrl_en_r;
    max_hold_nxt = max_hold_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CONTROL_ENABLED: ctrl_en_nxt  = cfg_data[0];
        CFG_MAX_HOLD:        max_hold_nxt = cfg_data;
        default:             ctrl_en_nxt  = ctrl_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_en_r  <= 1'b0;
      max_hold_r <= 31'd60000;
    end else begin
      ctrl_en_r  <= ctrl_en_nxt;
      max_hold_r <= max_hold_nxt;
    end
  end

  gbhs_front u_front (
    .ctrl_en  (ctrl_en_r),
    .max_hold (max_hold_r),
    .in_item  (in_item),
    .cmd      (front_cmd)
  );

  assign in_stall = q_full;

  gbhs_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head_bits)
  );

  gbhs_back #(
    .RELEASE_SLOTS (RELEASE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (cmd_t'(q_head_bits)),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/gbhs_ram.sv -----
module gbhs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/gbhs_front.sv -----
module gbhs_front (
  input  logic               ctrl_en,
  input  logic [30:0]        max_hold,
  input  gbhs_pkg::in_item_t in_item,
  output gbhs_pkg::cmd_t     cmd
);
  import gbhs_pkg::*;

  logic hold_nz;
  logic too_long;

  assign hold_nz  = |in_item.hold_ms;
  assign too_long = in_item.hold_ms > {1'b0, max_hold};

  always_comb begin
    cmd             = '0;
    cmd.is_tick     = (in_item.opcode == OP_TICK);
    cmd.skip        = (in_item.opcode == OP_TICK) && !ctrl_en;
    cmd.hold_nz     = hold_nz;
    cmd.now_ms      = in_item.now_ms;
    cmd.pin         = in_item.pin;
    cmd.end_state   = in_item.end_state;
    cmd.hold_ms     = in_item.hold_ms;
    cmd.verdict     = in_item.set_verdict;
    cmd.pre_status  = STS_OK;
    priority if (!ctrl_en) begin
      cmd.pre_reject = 1'b1;
      cmd.pre_status = STS_NOT_PERMITTED;
    end else if (hold_nz && (too_long || in_item.end_state == PIN_STATE_INVALID)) begin
      cmd.pre_reject = 1'b1;
      cmd.pre_status = STS_INVALID_ARG;
    end else begin
      cmd.pre_reject = 1'b0;
    end
  end

endmodule

// ----- rtl/gbhs_queue.sv -----
module gbhs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] buf_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = buf_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/gbhs_back.sv -----
module gbhs_back #(
  parameter int RELEASE_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  gbhs_pkg::cmd_t      q_head,
  output logic                q_pop,
  input  logic                out_stall,
  output logic                out_valid,
  output gbhs_pkg::out_item_t out_item
);
  import gbhs_pkg::*;

  localparam int IDX_W = (RELEASE_SLOTS > 1) ? $clog2(RELEASE_SLOTS) : 1;
  localparam int ENT_W = $bits(slot_entry_t);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]               state_r, state_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [RELEASE_SLOTS-1:0] active_r, active_nxt;
  logic                     found_v_r, found_v_nxt;
  logic [IDX_W-1:0]         found_r, found_nxt;
  logic                     free_v_r, free_v_nxt;
  logic [IDX_W-1:0]         free_r, free_nxt;
  logic                     pend_v_r, pend_v_nxt;
  logic [5:0]               pend_pin_r, pend_pin_nxt;
  logic [1:0]               pend_st_r, pend_st_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  slot_entry_t      wentry;
  slot_entry_t      rentry;
  logic [ENT_W-1:0] rdata;

  logic        out_free;
  logic        cur_active;
  logic        hit;
  logic        expired;
  logic [31:0] diff;
  logic        last_idx;
  logic        go;
  logic        done;
  logic [2:0]  verdict_sts;
  logic [2:0]  fin_sts;
  logic [IDX_W-1:0] slot_sel;

  gbhs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RELEASE_SLOTS),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rentry     = slot_entry_t'(rdata);
  assign out_free   = !out_valid_r || !out_stall;
  assign cur_active = active_r[idx_r];
  assign hit        = cur_active && (rentry.pin == cmd_r.pin);
  assign diff       = cmd_r.now_ms - rentry.deadline;
  assign expired    = cur_active && !diff[31];
  assign last_idx   = (idx_r == IDX_W'(RELEASE_SLOTS - 1));
  assign slot_sel   = found_v_r ? found_r : free_r;

  always_comb begin
    unique case (cmd_r.verdict)
      VERDICT_OK:      verdict_sts = STS_OK;
      VERDICT_IN_USE:  verdict_sts = STS_NOT_PERMITTED;
      VERDICT_BAD_ARG: verdict_sts = STS_INVALID_ARG;
      VERDICT_OTHER:   verdict_sts = STS_UNKNOWN;
      default:         verdict_sts = STS_UNKNOWN;
    endcase
  end

  always_comb begin
    priority if (cmd_r.pre_reject) begin
      fin_sts = cmd_r.pre_status;
    end else if (cmd_r.hold_nz && !found_v_r && !free_v_r) begin
      fin_sts = STS_PRECONDITION;
    end else begin
      fin_sts = verdict_sts;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    active_nxt    = active_r;
    found_v_nxt   = found_v_r;
    found_nxt     = found_r;
    free_v_nxt    = free_v_r;
    free_nxt      = free_r;
    pend_v_nxt    = pend_v_r;
    pend_pin_nxt  = pend_pin_r;
    pend_st_nxt   = pend_st_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    raddr         = idx_r;
    we            = 1'b0;
    waddr         = slot_sel;
    wentry.pin         = cmd_r.pin;
    wentry.end_state   = cmd_r.end_state;
    wentry.deadline    = cmd_r.now_ms + cmd_r.hold_ms;
    q_pop         = 1'b0;
    go            = 1'b0;
    done          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_head;
          idx_nxt     = '0;
          raddr       = '0;
          found_v_nxt = 1'b0;
          free_v_nxt  = 1'b0;
          pend_v_nxt  = 1'b0;
          n_nxt       = '0;
          if (q_head.is_tick) begin
            state_nxt = q_head.skip ? S_IDLE : S_SCAN;
          end else begin
            state_nxt = q_head.pre_reject ? S_FIN : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        go = !cmd_r.is_tick || !expired || !pend_v_r || out_free;
        if (go) begin
          if (!cmd_r.is_tick) begin
            if (hit && !found_v_r) begin
              found_v_nxt = 1'b1;
              found_nxt   = idx_r;
            end
            if (!cur_active && !free_v_r) begin
              free_v_nxt = 1'b1;
              free_nxt   = idx_r;
            end
          end else if (expired) begin
            active_nxt[idx_r] = 1'b0;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{kind: KIND_RELEASE, status: STS_OK,
                                release_pin: pend_pin_r, release_state: pend_st_r,
                                last: 1'b0};
            end
            pend_v_nxt   = 1'b1;
            pend_pin_nxt = rentry.pin;
            pend_st_nxt  = rentry.end_state;
            n_nxt        = n_r + CNT_W'(1);
          end
          done = last_idx || (cmd_r.is_tick && expired && n_r == CNT_W'(OUT_CAP - 1));
          if (done) begin
            state_nxt = cmd_r.is_tick ? S_FLUSH : S_FIN;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            raddr   = idx_r + IDX_W'(1);
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_STATUS, status: fin_sts, release_pin: 6'd0,
                            release_state: 2'd0, last: 1'b1};
          if (fin_sts == STS_OK) begin
            if (cmd_r.hold_nz) begin
              we                   = 1'b1;
              active_nxt[slot_sel] = 1'b1;
            end else if (found_v_r) begin
              active_nxt[found_r] = 1'b0;
            end
          end
          state_nxt = S_IDLE;
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_RELEASE, status: STS_OK,
                            release_pin: pend_pin_r, release_state: pend_st_r,
                            last: 1'b1};
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      found_v_r   <= 1'b0;
      free_v_r    <= 1'b0;
      n_r         <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      found_v_r   <= found_v_nxt;
      free_v_r    <= free_v_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    found_r    <= found_nxt;
    free_r     <= free_nxt;
    pend_pin_r <= pend_pin_nxt;
    pend_st_r  <= pend_st_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
